// ----- hw/rtl/slme_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list merge package
// Shared types, widths and codes for the two-way sorted list merge engine.
// ----------------------------------------------------------------------------
package slme_pkg;

  // Value width and list storage geometry.
  localparam int VAL_W      = 64;
  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(LIST_DEPTH);

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2
  } op_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRIME = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  // Decision of the compare unit for one merge step.
  typedef struct packed {
    logic take_first;
    logic is_last;
  } pick_t;

endpackage

// ----- hw/rtl/slme_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module slme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port with the data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/slme_pick.sv -----
// ----------------------------------------------------------------------------
// Merge compare unit
// Compares the two list heads and decides which one leaves next, and whether
// it is the final value of the run.
// ----------------------------------------------------------------------------
module slme_pick (
  input  logic signed [slme_pkg::VAL_W-1:0] head_first,
  input  logic signed [slme_pkg::VAL_W-1:0] head_second,
  input  logic [slme_pkg::CNT_W-1:0]        ptr_first,
  input  logic [slme_pkg::CNT_W-1:0]        ptr_second,
  input  logic [slme_pkg::CNT_W-1:0]        cnt_first,
  input  logic [slme_pkg::CNT_W-1:0]        cnt_second,
  output slme_pkg::pick_t                   pick
);
  import slme_pkg::*;

  logic           first_left;
  logic           second_left;
  logic [CNT_W:0] done_sum;
  logic [CNT_W:0] total;

  // While both lists hold values, the first list wins only when strictly smaller; ties go to the second list.
  assign first_left  = ptr_first < cnt_first;
  assign second_left = ptr_second < cnt_second;
  assign pick.take_first = !second_left || (first_left && (head_first < head_second));

  // The value leaving now is the last one when it completes the total count.
  assign done_sum = {1'b0, ptr_first} + {1'b0, ptr_second} + (CNT_W+1)'(1);
  assign total    = {1'b0, cnt_first} + {1'b0, cnt_second};
  assign pick.is_last = done_sum == total;

endmodule

// ----- hw/rtl/sorted_list_merge_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted list merge engine
// Two ascending lists of signed values are loaded into two RAMs; a merge
// request emits all stored values as one ascending stream.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   start / busy           op, value
//  result    res_strobe (1 cycle)   merged_value, last, empty_res, overflowed
//
//  An append request is taken while idle; appends may follow back to back.
//  A merge first passes the priming state for the RAM reads and then emits
//  the stored values one per cycle; busy stays high from priming until the
//  last value (through priming alone for two empty lists), and the next
//  request is taken once busy falls; the shared compare unit and the
//  registered RAM read set this pace.
//  Results appear in the cycle after each step; the receiver cannot stall them.
//  Synchronous reset clears the counts, the overflow flag and the sequencer;
//  the list RAMs are not cleared and hold no meaning until written.
// ----------------------------------------------------------------------------
module sorted_list_merge_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic signed [slme_pkg::VAL_W-1:0] value,
  output logic                        res_strobe,
  output logic signed [slme_pkg::VAL_W-1:0] merged_value,
  output logic                        last,
  output logic                        empty_res,
  output logic                        overflowed
);
  import slme_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt_first;
  logic [CNT_W-1:0]  cnt_second;
  logic [CNT_W-1:0]  ptr_first;
  logic [CNT_W-1:0]  ptr_first_next;
  logic [CNT_W-1:0]  ptr_second;
  logic [CNT_W-1:0]  ptr_second_next;
  logic              dropped_flag;
  logic              accept;
  logic              we_first;
  logic              we_second;
  logic [VAL_W-1:0]  rdata_first;
  logic [VAL_W-1:0]  rdata_second;
  pick_t             pick;
  logic              emit;
  logic [VAL_W-1:0]  emit_value;
  logic              emit_last;
  logic              emit_empty;
  logic              clear;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  // Appends are written only while the chosen list has room.
  assign we_first  = accept && (op == OP_APPEND_FIRST) && (cnt_first < LIST_FULL);
  assign we_second = accept && (op == OP_APPEND_SECOND) && (cnt_second < LIST_FULL);

  // List storage; reads follow the next pointers so heads are ready each cycle.
  slme_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_first (
    .clk   (clk),
    .we    (we_first),
    .waddr (cnt_first[ADDR_W-1:0]),
    .wdata (value),
    .raddr (ptr_first_next[ADDR_W-1:0]),
    .rdata (rdata_first)
  );

  slme_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram_second (
    .clk   (clk),
    .we    (we_second),
    .waddr (cnt_second[ADDR_W-1:0]),
    .wdata (value),
    .raddr (ptr_second_next[ADDR_W-1:0]),
    .rdata (rdata_second)
  );

  // Shared compare unit.
  slme_pick u_pick (
    .head_first  (rdata_first),
    .head_second (rdata_second),
    .ptr_first   (ptr_first),
    .ptr_second  (ptr_second),
    .cnt_first   (cnt_first),
    .cnt_second  (cnt_second),
    .pick        (pick)
  );

  // Sequencer: prime the RAM reads, then emit one value per cycle; two empty lists give a single empty result.
  always_comb begin
    state_next      = state;
    ptr_first_next  = ptr_first;
    ptr_second_next = ptr_second;
    emit            = 1'b0;
    emit_value      = '0;
    emit_last       = 1'b0;
    emit_empty      = 1'b0;
    clear           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_MERGE)) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        if ((cnt_first == '0) && (cnt_second == '0)) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_empty = 1'b1;
          clear      = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        emit      = 1'b1;
        emit_last = pick.is_last;
        if (pick.take_first) begin
          emit_value     = rdata_first;
          ptr_first_next = ptr_first + CNT_W'(1);
        end else begin
          emit_value      = rdata_second;
          ptr_second_next = ptr_second + CNT_W'(1);
        end
        if (pick.is_last) begin
          clear      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (clear) begin
      ptr_first_next  = '0;
      ptr_second_next = '0;
    end
  end

  // Control state: sequencer, pointers, counts and the sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ptr_first    <= '0;
      ptr_second   <= '0;
      cnt_first    <= '0;
      cnt_second   <= '0;
      dropped_flag <= 1'b0;
      res_strobe   <= 1'b0;
    end else begin
      state      <= state_next;
      ptr_first  <= ptr_first_next;
      ptr_second <= ptr_second_next;
      res_strobe <= emit;
      if (clear) begin
        cnt_first    <= '0;
        cnt_second   <= '0;
        dropped_flag <= 1'b0;
      end else begin
        if (we_first) begin
          cnt_first <= cnt_first + CNT_W'(1);
        end
        if (we_second) begin
          cnt_second <= cnt_second + CNT_W'(1);
        end
        if (accept && !we_first && (op == OP_APPEND_FIRST)) begin
          dropped_flag <= 1'b1;
        end
        if (accept && !we_second && (op == OP_APPEND_SECOND)) begin
          dropped_flag <= 1'b1;
        end
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      merged_value <= emit_value;
      last         <= emit_last;
      empty_res    <= emit_empty;
      overflowed   <= dropped_flag;
    end
  end

endmodule

// ----- hw/rtl/slme_checker.sv -----
// ----------------------------------------------------------------------------
// Merge engine port checker
// Watches the top level's ports for sequencing slips, bound to the top level.
// ----------------------------------------------------------------------------
module slme_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  op,
  input logic                        res_strobe,
  input logic [slme_pkg::VAL_W-1:0]  merged_value,
  input logic                        last,
  input logic                        empty_res
);
  import slme_pkg::*;

  // An accepted merge request makes the engine busy in the next cycle.
  a_merge_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op == OP_MERGE) |=> busy)
    else $error("merge request did not raise busy");

  // Busy only rises after an accepted merge request.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (op == OP_MERGE)))
    else $error("busy rose without a merge request");

  // The empty result is a single zero result that ends the run.
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    res_strobe && empty_res |-> last && (merged_value == '0))
    else $error("malformed empty result");

  // A result that is not the last one comes while the engine is still busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    res_strobe && !last |-> busy)
    else $error("intermediate result while idle");

  // The engine is free again when the last result is shown.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_strobe && last |-> !busy)
    else $error("engine still busy at the last result");

endmodule

bind sorted_list_merge_engine_unit slme_checker u_slme_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .res_strobe   (res_strobe),
  .merged_value (merged_value),
  .last         (last),
  .empty_res    (empty_res)
);

// ----- tb/sorted_list_merge_engine_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted list merge engine testbench
// Loads two lists with append requests and merges them. Every expected output
// value is predicted when its request is accepted, and each strobed result is
// checked against it field by field. Directed cases come first: the empty
// merge, value extremes with ties, one-sided merges, the unused op code and overfull lists.
// Random merge rounds follow: mostly ascending lists, some unsorted lists,
// noise requests, and lists filled beyond their depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_list_merge_engine_unit_tb;
  import slme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam int RANDOM_ITEMS = 200;

  typedef logic signed [VAL_W-1:0] value_q_t[$];

  typedef struct {
    logic signed [VAL_W-1:0] val;
    logic                    last;
    logic                    empty;
    logic                    ovf;
  } merge_result_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              op;
  logic signed [VAL_W-1:0] value;
  logic                    res_strobe;
  logic signed [VAL_W-1:0] merged_value;
  logic                    last;
  logic                    empty_res;
  logic                    overflowed;

  // Predicted contents of the two lists and the sticky drop flag.
  logic signed [VAL_W-1:0] first_list_copy[$];
  logic signed [VAL_W-1:0] second_list_copy[$];
  logic                    drop_seen;

  merge_result_t pending_merge_results[$];
  merge_result_t want;
  int            fail_count;
  int            items_sent;
  int            burst_left;

  sorted_list_merge_engine_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .value        (value),
    .res_strobe   (res_strobe),
    .merged_value (merged_value),
    .last         (last),
    .empty_res    (empty_res),
    .overflowed   (overflowed)
  );

  // Clock generation.
  always #4 clk = ~clk;

  // Works out the results that one accepted request causes.
  function automatic void predict_request(logic [1:0] code, logic signed [VAL_W-1:0] data);
    merge_result_t r;
    int            i;
    int            j;
    int            total;
    i = 0;
    j = 0;
    case (code)
      OP_APPEND_FIRST: begin
        if (first_list_copy.size() >= LIST_DEPTH) drop_seen = 1'b1;
        else first_list_copy.push_back(data);
      end
      OP_APPEND_SECOND: begin
        if (second_list_copy.size() >= LIST_DEPTH) drop_seen = 1'b1;
        else second_list_copy.push_back(data);
      end
      OP_MERGE: begin
        total = first_list_copy.size() + second_list_copy.size();
        r.ovf = drop_seen;
        if (total == 0) begin
          r.val   = '0;
          r.last  = 1'b1;
          r.empty = 1'b1;
          pending_merge_results.push_back(r);
        end else begin
          r.empty = 1'b0;
          while (i < first_list_copy.size() || j < second_list_copy.size()) begin
            // On a tie the second list goes out first.
            if (j >= second_list_copy.size() ||
                (i < first_list_copy.size() && first_list_copy[i] < second_list_copy[j])) begin
              r.val = first_list_copy[i];
              i++;
            end else begin
              r.val = second_list_copy[j];
              j++;
            end
            r.last = (i + j == total);
            pending_merge_results.push_back(r);
          end
        end
        first_list_copy.delete();
        second_list_copy.delete();
        drop_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Sends one request and then, at the end of a burst, leaves a random gap.
  task automatic send_request(logic [1:0] code, logic signed [VAL_W-1:0] data);
    start <= 1'b1;
    op    <= code;
    value <= data;
    do @(posedge clk); while (busy);
    predict_request(code, data);
    if (code != OP_UNUSED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Holds requests back until every predicted result has come out.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_merge_results.size() != 0);
  endtask

  // Builds a list of n values, ascending from base unless shuffled is set.
  function automatic value_q_t build_run(int n, bit narrow, bit shuffled,
                                         logic signed [VAL_W-1:0] base);
    value_q_t                run;
    logic signed [VAL_W-1:0] cur;
    logic [VAL_W-1:0]        step;
    logic [VAL_W:0]          sum;
    cur = base;
    for (int k = 0; k < n; k++) begin
      if (shuffled) begin
        cur = {$urandom, $urandom};
      end else begin
        step = narrow ? VAL_W'($urandom_range(0, 3))
                      : {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
        sum  = {cur[VAL_W-1], cur} + {1'b0, step};
        // Saturate at the top of the range, which also yields ties there.
        cur  = (sum[VAL_W] != sum[VAL_W-1]) ? VAL_MAX : sum[VAL_W-1:0];
      end
      run.push_back(cur);
    end
    return run;
  endfunction

  // Sends two lists with the appends interleaved at random, then a merge.
  task automatic send_merge_round(value_q_t run_first, value_q_t run_second, bit noise);
    int i;
    int j;
    i = 0;
    j = 0;
    while (i < run_first.size() || j < run_second.size()) begin
      if (j >= run_second.size() || (i < run_first.size() && $urandom_range(0, 1))) begin
        send_request(OP_APPEND_FIRST, run_first[i]);
        i++;
      end else begin
        send_request(OP_APPEND_SECOND, run_second[j]);
        j++;
      end
      if (noise && $urandom_range(0, 15) == 0) send_request(OP_UNUSED, {$urandom, $urandom});
    end
    send_request(OP_MERGE, {$urandom, $urandom});
  endtask

  // Result checker: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_strobe) begin
      if (pending_merge_results.size() == 0) begin
        $error("unexpected result: merged_value %0d last %0b", merged_value, last);
        fail_count++;
      end else begin
        want = pending_merge_results.pop_front();
        if (merged_value !== want.val) begin
          $error("merged_value: expected %0d, got %0d", want.val, merged_value);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          fail_count++;
        end
        if (empty_res !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, empty_res);
          fail_count++;
        end
        if (overflowed !== want.ovf) begin
          $error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
          fail_count++;
        end
      end
    end
  end

  // A merge with both lists empty gives one result marked empty.
  task automatic test_empty_merge();
    send_request(OP_MERGE, '0);
    wait_for_results();
  endtask

  // Extreme values in both lists, with ties at both ends of the range.
  task automatic test_extremes();
    send_request(OP_APPEND_FIRST, VAL_MIN);
    send_request(OP_APPEND_SECOND, VAL_MIN);
    send_request(OP_APPEND_FIRST, '0);
    send_request(OP_APPEND_SECOND, -64'sd1);
    send_request(OP_APPEND_FIRST, VAL_MAX);
    send_request(OP_APPEND_SECOND, VAL_MAX);
    send_request(OP_MERGE, '1);
  endtask

  // Only one list holds values: the merge gives that list in order.
  task automatic test_one_sided();
    send_request(OP_APPEND_FIRST, 64'sd5);
    send_request(OP_APPEND_FIRST, 64'sd7);
    send_request(OP_MERGE, VAL_MAX);
    send_request(OP_APPEND_SECOND, -64'sd3);
    send_request(OP_MERGE, VAL_MIN);
  endtask

  // The unused op code must leave the state untouched.
  task automatic test_unused_op();
    send_request(OP_UNUSED, VAL_MAX);
    send_request(OP_MERGE, '0);
    send_request(OP_APPEND_FIRST, 64'sd1);
    send_request(OP_UNUSED, '1);
    send_request(OP_APPEND_SECOND, 64'sd1);
    send_request(OP_MERGE, '0);
    wait_for_results();
  endtask

  // Appends beyond a full list are dropped and flag the whole merge.
  task automatic test_overflow();
    send_merge_round(build_run(LIST_DEPTH + 2, 1'b0, 1'b0, VAL_MIN),
                     build_run(3, 1'b1, 1'b0, '0), 1'b0);
    wait_for_results();
    // Both lists full: the longest merge there is.
    send_merge_round(build_run(LIST_DEPTH, 1'b1, 1'b0, -64'sd40),
                     build_run(LIST_DEPTH + 1, 1'b1, 1'b0, -64'sd40), 1'b0);
    wait_for_results();
  endtask

  // Random merge rounds of random sizes and value spreads.
  task automatic test_random_merges();
    int                      goal;
    int                      n_first;
    int                      n_second;
    int                      shape;
    bit                      narrow;
    bit                      shuffled;
    logic signed [VAL_W-1:0] base;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      shape = $urandom_range(0, 15);
      if (shape < 10) begin
        n_first  = $urandom_range(0, 6);
        n_second = $urandom_range(0, 6);
      end else if (shape < 14) begin
        n_first  = $urandom_range(0, LIST_DEPTH);
        n_second = $urandom_range(0, LIST_DEPTH);
      end else begin
        n_first  = LIST_DEPTH + $urandom_range(0, 2);
        n_second = $urandom_range(0, 4);
        if (shape == 15) begin
          n_second = n_first;
          n_first  = $urandom_range(0, 4);
        end
      end
      narrow   = $urandom_range(0, 1);
      shuffled = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
        0:       base = {$urandom, $urandom};
        1:       base = VAL_MIN;
        2:       base = VAL_MAX - VAL_W'($urandom_range(0, 40));
        default: base = $signed(VAL_W'($urandom_range(0, 200))) - 64'sd100;
      endcase
      send_merge_round(build_run(n_first, narrow, shuffled, base),
                       build_run(n_second, narrow, shuffled, base), 1'b1);
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
  endtask

  // Main sequence.
  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    op         = OP_APPEND_FIRST;
    value      = '0;
    drop_seen  = 1'b0;
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_merge();
    test_extremes();
    test_one_sided();
    test_unused_op();
    test_overflow();
    test_random_merges();
    wait_for_results();
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_merge_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
